// ===== src/spatial_audio_attenuation_pan_defines.svh =====
// assertion macros shared by the spatial audio block
`ifndef SPATIAL_AUDIO_ATTENUATION_PAN_DEFINES_SVH
`define SPATIAL_AUDIO_ATTENUATION_PAN_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define SAP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sap assertion failed");

// antecedent holds -> consequent holds after the delay dly
`define SAP_ASSERT_DELAY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("sap latency assertion failed");

`endif

// ===== src/sap_pkg.sv =====
// ----------------------------------------------------------------------------
// sap_pkg
// shared constants and types of the spatial attenuation and pan pipeline
// ----------------------------------------------------------------------------
package sap_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int CFG_WIDTH       = 24;
	localparam int BLEND_WIDTH     = 16;
	localparam int DIST_CFG_WIDTH  = 24;
	localparam int AXIS_WIDTH      = 16;
	localparam int ATT_WIDTH       = 16;
	localparam int PAN_WIDTH       = 17;
	localparam int DIV_STEPS       = 16;
	localparam int FRAC_BITS       = 15;
	localparam logic [15:0] UNITY  = 16'd32768;

	typedef enum logic [1:0] {
		REG_BLEND    = 2'd0,
		REG_MIN_DIST = 2'd1,
		REG_MAX_DIST = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FALL_UNITY = 2'd0,
		FALL_ZERO  = 2'd1,
		FALL_DIV   = 2'd2
	} fall_sel_t;

	// control that travels with the pan divide
	typedef struct packed {
		logic byp;
		logic neg;
		logic ovf;
		logic zero;
	} pan_sb_t;

endpackage

// ===== src/sap_isqrt.sv =====
// ----------------------------------------------------------------------------
// sap_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module sap_isqrt import sap_pkg::*; #(
	parameter int RW = 34,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [RW-1:0] radicand,
	input  logic [SW-1:0] in_sb,
	output logic          out_valid,
	output logic [RW/2-1:0] root,
	output logic [SW-1:0] out_sb
);

	localparam int N   = RW / 2;
	localparam int RMW = N + 2;

	logic          v_sn    [N];
	logic [N-1:0]  root_sn [N];
	logic [RMW-1:0] rem_sn [N];
	logic [RW-1:0] rad_sn  [N];
	logic [SW-1:0] sb_sn   [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic          v_in;
		logic [N-1:0]  root_in;
		logic [RMW-1:0] rem_in;
		logic [RW-1:0] rad_in;
		logic [SW-1:0] sb_in;
		logic [RMW+1:0] cand;
		logic [RMW+1:0] trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign root_in = '0;
			assign rem_in  = '0;
			assign rad_in  = radicand;
			assign sb_in   = in_sb;
		end else begin : g_next
			assign v_in    = v_sn[k-1];
			assign root_in = root_sn[k-1];
			assign rem_in  = rem_sn[k-1];
			assign rad_in  = rad_sn[k-1];
			assign sb_in   = sb_sn[k-1];
		end

		// trial subtract of 4*root+1 from the remainder
		assign cand  = {rem_in, rad_in[RW-1 -: 2]};
		assign trial = {{(RMW-N){1'b0}}, root_in, 2'b01};
		assign ge    = cand >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[k] <= 1'b0;
			end else begin
				v_sn[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			root_sn[k] <= {root_in[N-2:0], ge};
			rem_sn[k]  <= ge ? RMW'(cand - trial) : RMW'(cand);
			rad_sn[k]  <= {rad_in[RW-3:0], 2'b00};
			sb_sn[k]   <= sb_in;
		end
	end

	assign out_valid = v_sn[N-1];
	assign root      = root_sn[N-1];
	assign out_sb    = sb_sn[N-1];

endmodule

// ===== src/sap_div.sv =====
// ----------------------------------------------------------------------------
// sap_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module sap_div import sap_pkg::*; #(
	parameter int DW = 24,
	parameter int K  = 16,
	parameter int SW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] rem_init,
	input  logic [K-1:0]  low_bits,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] in_sb,
	output logic          out_valid,
	output logic [K-1:0]  quot,
	output logic [SW-1:0] out_sb
);

	logic          v_sn   [K];
	logic [DW-1:0] rem_sn [K];
	logic [K-1:0]  low_sn [K];
	logic [K-1:0]  q_sn   [K];
	logic [DW-1:0] div_sn [K];
	logic [SW-1:0] sb_sn  [K];

	for (genvar k = 0; k < K; k++) begin : g_stage
		logic          v_in;
		logic [DW-1:0] rem_in;
		logic [K-1:0]  low_in;
		logic [K-1:0]  q_in;
		logic [DW-1:0] div_in;
		logic [SW-1:0] sb_in;
		logic [DW:0]   cand;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in   = in_valid;
			assign rem_in = rem_init;
			assign low_in = low_bits;
			assign q_in   = '0;
			assign div_in = divisor;
			assign sb_in  = in_sb;
		end else begin : g_next
			assign v_in   = v_sn[k-1];
			assign rem_in = rem_sn[k-1];
			assign low_in = low_sn[k-1];
			assign q_in   = q_sn[k-1];
			assign div_in = div_sn[k-1];
			assign sb_in  = sb_sn[k-1];
		end

		assign cand = {rem_in, low_in[K-1]};
		assign ge   = cand >= {1'b0, div_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sn[k] <= 1'b0;
			end else begin
				v_sn[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[k] <= ge ? DW'(cand - {1'b0, div_in}) : DW'(cand);
			low_sn[k] <= {low_in[K-2:0], 1'b0};
			q_sn[k]   <= {q_in[K-2:0], ge};
			div_sn[k] <= div_in;
			sb_sn[k]  <= sb_in;
		end
	end

	assign out_valid = v_sn[K-1];
	assign quot      = q_sn[K-1];
	assign out_sb    = sb_sn[K-1];

endmodule

// ===== src/spatial_audio_attenuation_pan.sv =====
// ----------------------------------------------------------------------------
// spatial_audio_attenuation_pan
// distance gain and stereo pan of one source per item, fully pipelined
// ----------------------------------------------------------------------------
// channel   ports                                   transfer
// input     start, busy, source_*, listener_*,      start && !busy
//           right_*, listener_present
// result    done, attenuation, pan                  done (one cycle)
// config    cfg_we, cfg_index, cfg_wdata            cfg_we
//
// one item enters every cycle; busy is always low
// the pipeline has three front stages, one square root stage per root bit,
// one setup stage, 16 divider stages and one output stage
// reset clears valid bits and config registers only
// the result side cannot stall, so the pipeline never holds
`include "spatial_audio_attenuation_pan_defines.svh"

module spatial_audio_attenuation_pan import sap_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] source_x,
	input  logic signed [COORD_WIDTH-1:0] source_y,
	input  logic signed [COORD_WIDTH-1:0] source_z,
	input  logic signed [COORD_WIDTH-1:0] listener_x,
	input  logic signed [COORD_WIDTH-1:0] listener_y,
	input  logic signed [COORD_WIDTH-1:0] listener_z,
	input  logic signed [AXIS_WIDTH-1:0]  right_x,
	input  logic signed [AXIS_WIDTH-1:0]  right_y,
	input  logic signed [AXIS_WIDTH-1:0]  right_z,
	input  logic                          listener_present,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [CFG_WIDTH-1:0]          cfg_wdata,
	output logic                          done,
	output logic [ATT_WIDTH-1:0]          attenuation,
	output logic signed [PAN_WIDTH-1:0]   pan
);

	localparam int W    = COORD_WIDTH;
	localparam int DWD  = W + 1;
	localparam int SQW  = 2 * W + 2;
	localparam int PRW  = W + 1 + AXIS_WIDTH;
	localparam int DOTW = W + 18;
	localparam int MAGW = W + 17;
	localparam int CMPW = (DWD > DIST_CFG_WIDTH) ? DWD : DIST_CFG_WIDTH;
	localparam int SBW  = MAGW + 2;
	localparam int LAT  = W + 22;

	// configuration registers
	logic [BLEND_WIDTH-1:0]    blend_q;
	logic [DIST_CFG_WIDTH-1:0] min_q;
	logic [DIST_CFG_WIDTH-1:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= '0;
			min_q   <= DIST_CFG_WIDTH'(256);
			max_q   <= DIST_CFG_WIDTH'(12800);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLEND:    blend_q <= cfg_wdata[BLEND_WIDTH-1:0];
				REG_MIN_DIST: min_q   <= cfg_wdata[DIST_CFG_WIDTH-1:0];
				REG_MAX_DIST: max_q   <= cfg_wdata[DIST_CFG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stage 1: offsets
	logic                   valid_s1, byp_s1;
	logic signed [DWD-1:0]  dx_s1, dy_s1, dz_s1;
	logic signed [AXIS_WIDTH-1:0] rx_s1, ry_s1, rz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		byp_s1 <= (blend_q == '0) || !listener_present;
		dx_s1  <= DWD'(source_x) - DWD'(listener_x);
		dy_s1  <= DWD'(source_y) - DWD'(listener_y);
		dz_s1  <= DWD'(source_z) - DWD'(listener_z);
		rx_s1  <= right_x;
		ry_s1  <= right_y;
		rz_s1  <= right_z;
	end

	// stage 2: squares and axis products
	logic [DWD-1:0] ax, ay, az;
	assign ax = dx_s1[DWD-1] ? DWD'(-dx_s1) : DWD'(dx_s1);
	assign ay = dy_s1[DWD-1] ? DWD'(-dy_s1) : DWD'(dy_s1);
	assign az = dz_s1[DWD-1] ? DWD'(-dz_s1) : DWD'(dz_s1);

	logic                  valid_s2, byp_s2;
	logic [SQW-1:0]        sqx_s2, sqy_s2, sqz_s2;
	logic signed [PRW-1:0] px_s2, py_s2, pz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		byp_s2 <= byp_s1;
		sqx_s2 <= SQW'(ax) * SQW'(ax);
		sqy_s2 <= SQW'(ay) * SQW'(ay);
		sqz_s2 <= SQW'(az) * SQW'(az);
		px_s2  <= PRW'(dx_s1) * PRW'(rx_s1);
		py_s2  <= PRW'(dy_s1) * PRW'(ry_s1);
		pz_s2  <= PRW'(dz_s1) * PRW'(rz_s1);
	end

	// stage 3: sums
	logic signed [DOTW-1:0] dot;
	assign dot = DOTW'(px_s2) + DOTW'(py_s2) + DOTW'(pz_s2);

	logic            valid_s3, byp_s3, neg_s3;
	logic [SQW-1:0]  sum_s3;
	logic [MAGW-1:0] mag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		byp_s3 <= byp_s2;
		sum_s3 <= sqx_s2 + sqy_s2 + sqz_s2;
		neg_s3 <= dot[DOTW-1];
		mag_s3 <= dot[DOTW-1] ? MAGW'(-dot) : MAGW'(dot);
	end

	// square root
	logic            sq_valid;
	logic [DWD-1:0]  distance;
	logic [SBW-1:0]  sq_sb;

	sap_isqrt #(
		.RW (SQW),
		.SW (SBW)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.radicand  (sum_s3),
		.in_sb     ({byp_s3, neg_s3, mag_s3}),
		.out_valid (sq_valid),
		.root      (distance),
		.out_sb    (sq_sb)
	);

	// stage 4: divider setup
	logic [CMPW-1:0] dist_c, min_c, max_c;
	assign dist_c = CMPW'(distance);
	assign min_c  = CMPW'(min_q);
	assign max_c  = CMPW'(max_q);

	fall_sel_t fsel;
	always_comb begin
		if (!(max_q > min_q)) begin
			fsel = FALL_UNITY;
		end else if (dist_c >= max_c) begin
			fsel = FALL_ZERO;
		end else if (dist_c > min_c) begin
			fsel = FALL_DIV;
		end else begin
			fsel = FALL_UNITY;
		end
	end

	logic [DWD-1:0] side_hi;
	assign side_hi = sq_sb[MAGW-1 -: DWD];

	logic                      valid_s4;
	fall_sel_t                 fsel_s4;
	logic [DIST_CFG_WIDTH-1:0] frem_s4, span_s4;
	logic [DWD-1:0]            srem_s4, dist_s4;
	logic [DIV_STEPS-1:0]      slow_s4;
	pan_sb_t                   psb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		fsel_s4     <= fsel;
		frem_s4     <= DIST_CFG_WIDTH'(max_c - dist_c);
		span_s4     <= max_q - min_q;
		srem_s4     <= side_hi;
		slow_s4     <= sq_sb[DIV_STEPS-1:0];
		dist_s4     <= distance;
		psb_s4.byp  <= sq_sb[SBW-1];
		psb_s4.neg  <= sq_sb[SBW-2];
		psb_s4.ovf  <= side_hi >= distance;
		psb_s4.zero <= distance == '0;
	end

	// falloff divide, one extra quotient bit dropped at the end
	logic                 fa_valid;
	logic [DIV_STEPS-1:0] fa_quot;
	logic [1:0]           fa_sb;

	sap_div #(
		.DW (DIST_CFG_WIDTH),
		.K  (DIV_STEPS),
		.SW (2)
	) u_div_fall (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.rem_init  (frem_s4),
		.low_bits  ('0),
		.divisor   (span_s4),
		.in_sb     (fsel_s4),
		.out_valid (fa_valid),
		.quot      (fa_quot),
		.out_sb    (fa_sb)
	);

	// side divide of the projection by the distance
	logic                 sd_valid;
	logic [DIV_STEPS-1:0] sd_quot;
	pan_sb_t              sd_sb;

	sap_div #(
		.DW (DWD),
		.K  (DIV_STEPS),
		.SW ($bits(pan_sb_t))
	) u_div_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.rem_init  (srem_s4),
		.low_bits  (slow_s4),
		.divisor   (dist_s4),
		.in_sb     (psb_s4),
		.out_valid (sd_valid),
		.quot      (sd_quot),
		.out_sb    (sd_sb)
	);

	// output stage: blend
	logic [BLEND_WIDTH-1:0] blend_c;
	assign blend_c = (blend_q > UNITY) ? UNITY : blend_q;

	logic [ATT_WIDTH-1:0] falloff, one_minus;
	always_comb begin
		case (fall_sel_t'(fa_sb))
			FALL_ZERO: falloff = '0;
			FALL_DIV:  falloff = {1'b0, fa_quot[DIV_STEPS-1:1]};
			default:   falloff = UNITY;
		endcase
	end
	assign one_minus = UNITY - falloff;

	logic [31:0] att_prod, pan_prod;
	logic [ATT_WIDTH-1:0] side, p_mag;
	assign att_prod = 32'(blend_c) * 32'(one_minus);
	assign side     = (sd_sb.ovf || sd_quot > UNITY) ? UNITY : sd_quot;
	assign pan_prod = 32'(side) * 32'(blend_c);
	assign p_mag    = pan_prod[FRAC_BITS +: ATT_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sd_sb.byp) begin
			attenuation <= UNITY;
			pan         <= '0;
		end else begin
			attenuation <= UNITY - att_prod[FRAC_BITS +: ATT_WIDTH];
			if (sd_sb.zero) begin
				pan <= '0;
			end else if (sd_sb.neg) begin
				pan <= -$signed({1'b0, p_mag});
			end else begin
				pan <= $signed({1'b0, p_mag});
			end
		end
	end

	`SAP_ASSERT_SAME(a_div_lockstep, 1'b1, fa_valid == sd_valid)
	`SAP_ASSERT_SAME(a_att_range, done, attenuation <= UNITY)
	`SAP_ASSERT_SAME(a_pan_range, done, (pan <= 17'sd32768) && (pan >= -17'sd32768))
	`SAP_ASSERT_DELAY(a_no_listener, accept && !listener_present, LAT,
		done && attenuation == UNITY && pan == '0)

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks distance gain and stereo pan of the spatial audio pipeline against
// a bit-exact predictor, over directed corner items and bursty random traffic
// under several register settings
// ----------------------------------------------------------------------------
module tb_top;
	import sap_pkg::*;

	localparam int CW         = COORD_WIDTH_DEF;
	localparam int LATENCY    = CW + 22;
	localparam int WD_LIMIT   = 4000;
	localparam int PHASE_ITEMS = 110;
	// index past the register list, must be ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam longint unsigned ONE_Q15 = 32768;

	typedef struct {
		logic signed [CW-1:0]         sx, sy, sz, lx, ly, lz;
		logic signed [AXIS_WIDTH-1:0] rx, ry, rz;
		logic                         lp;
	} source_item_t;

	typedef struct {
		logic [ATT_WIDTH-1:0]        att;
		logic signed [PAN_WIDTH-1:0] pan;
	} gain_pan_t;

	typedef struct {
		source_item_t it;
		bit           typed;
		gain_pan_t    res;
	} dir_row_t;

	logic clk, arst_n, start, busy, cfg_we, done, listener_present;
	logic signed [CW-1:0] source_x, source_y, source_z, listener_x, listener_y, listener_z;
	logic signed [AXIS_WIDTH-1:0] right_x, right_y, right_z;
	logic [1:0] cfg_index;
	logic [CFG_WIDTH-1:0] cfg_wdata;
	logic [ATT_WIDTH-1:0] attenuation;
	logic signed [PAN_WIDTH-1:0] pan;

	longint unsigned blend_reg, min_reg, max_reg;
	gain_pan_t pending_results[$];
	int errors;
	int idle_cycles;

	spatial_audio_attenuation_pan dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic gain_pan_t predict_gain_pan(source_item_t it);
		longint d[3], r[3], dot;
		longint unsigned sumsq, distance, t, falloff, side, p, blend, mag;
		gain_pan_t o;
		o.att = ATT_WIDTH'(ONE_Q15);
		o.pan = '0;
		blend = blend_reg > ONE_Q15 ? ONE_Q15 : blend_reg;
		if (blend == 0 || !it.lp)
			return o;
		d[0] = longint'(it.sx) - longint'(it.lx);
		d[1] = longint'(it.sy) - longint'(it.ly);
		d[2] = longint'(it.sz) - longint'(it.lz);
		r[0] = longint'(it.rx); r[1] = longint'(it.ry); r[2] = longint'(it.rz);
		sumsq = 0;
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			sumsq += d[i] * d[i];
			dot += d[i] * r[i];
		end
		distance = 0;
		for (int b = 26; b >= 0; b--) begin
			t = distance | (64'd1 << b);
			if (t * t <= sumsq)
				distance = t;
		end
		falloff = ONE_Q15;
		if (max_reg > min_reg) begin
			if (distance >= max_reg)
				falloff = 0;
			else if (distance > min_reg)
				falloff = ((max_reg - distance) << 15) / (max_reg - min_reg);
		end
		o.att = ATT_WIDTH'(ONE_Q15 - ((blend * (ONE_Q15 - falloff)) >> 15));
		if (distance != 0) begin
			mag = dot < 0 ? -dot : dot;
			side = mag / distance;
			if (side > ONE_Q15)
				side = ONE_Q15;
			p = (side * blend) >> 15;
			o.pan = dot < 0 ? PAN_WIDTH'(-longint'(p)) : PAN_WIDTH'(p);
		end
		return o;
	endfunction

	function automatic source_item_t mk(longint sx, sy, sz, lx, ly, lz, rx, ry, rz, bit lp);
		source_item_t it;
		it.sx = CW'(sx); it.sy = CW'(sy); it.sz = CW'(sz);
		it.lx = CW'(lx); it.ly = CW'(ly); it.lz = CW'(lz);
		it.rx = AXIS_WIDTH'(rx); it.ry = AXIS_WIDTH'(ry); it.rz = AXIS_WIDTH'(rz);
		it.lp = lp;
		return it;
	endfunction

	function automatic dir_row_t row(source_item_t it, bit typed, longint att, longint pn);
		dir_row_t rw;
		rw.it = it;
		rw.typed = typed;
		rw.res.att = ATT_WIDTH'(att);
		rw.res.pan = PAN_WIDTH'(pn);
		return rw;
	endfunction

	function automatic source_item_t random_item();
		source_item_t it;
		int shift;
		it.rx = AXIS_WIDTH'($urandom);
		it.ry = AXIS_WIDTH'($urandom);
		it.rz = AXIS_WIDTH'($urandom);
		it.lp = ($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 3) == 0) begin
			it.sx = CW'($urandom); it.sy = CW'($urandom); it.sz = CW'($urandom);
			it.lx = CW'($urandom); it.ly = CW'($urandom); it.lz = CW'($urandom);
		end else begin
			// listener and offset kept in range so the source still fits
			shift = $urandom_range(1, 23);
			it.lx = $signed(CW'($urandom)) >>> 1;
			it.ly = $signed(CW'($urandom)) >>> 1;
			it.lz = $signed(CW'($urandom)) >>> 1;
			it.sx = it.lx + ($signed(CW'($urandom)) >>> shift);
			it.sy = it.ly + ($signed(CW'($urandom)) >>> shift);
			it.sz = it.lz + ($signed(CW'($urandom)) >>> shift);
		end
		return it;
	endfunction

	task automatic write_reg(logic [1:0] idx, longint unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_WIDTH'(val);
		case (idx)
			REG_BLEND:    blend_reg = val & 64'hFFFF;
			REG_MIN_DIST: min_reg = val & 64'hFFFFFF;
			REG_MAX_DIST: max_reg = val & 64'hFFFFFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// start stays high across back-to-back items, lowered only by a gap
	task automatic send_item(source_item_t it);
		@(negedge clk);
		start <= 1'b1;
		source_x <= it.sx; source_y <= it.sy; source_z <= it.sz;
		listener_x <= it.lx; listener_y <= it.ly; listener_z <= it.lz;
		right_x <= it.rx; right_y <= it.ry; right_z <= it.rz;
		listener_present <= it.lp;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_gain_pan(it));
	endtask

	task automatic gap(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic drain();
		gap(1);
		wait (pending_results.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && n > 0; k++, n--)
				send_item(random_item());
			if ($urandom_range(0, 2) != 0)
				gap($urandom_range(1, 12));
		end
		drain();
	endtask

	// result check against the oldest expectation
	always @(posedge clk) begin
		gain_pan_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected att=%0d pan=%0d",
					$time, attenuation, pan);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (attenuation !== exp_r.att) begin
					$display("%0t: attenuation expected %0d actual %0d",
						$time, exp_r.att, attenuation);
					errors++;
				end
				if (pan !== exp_r.pan) begin
					$display("%0t: pan expected %0d actual %0d", $time, exp_r.pan, pan);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("[spatial_audio_attenuation_pan] ERROR");
			$finish;
		end
	end

	initial begin
		dir_row_t tab[$];
		arst_n = 0;
		start = 0; cfg_we = 0; cfg_index = REG_BLEND; cfg_wdata = 0;
		source_x = 0; source_y = 0; source_z = 0;
		listener_x = 0; listener_y = 0; listener_z = 0;
		right_x = 0; right_y = 0; right_z = 0; listener_present = 0;
		blend_reg = 0; min_reg = 256; max_reg = 12800;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset blend is zero: every result is unity and centered
		for (int k = 0; k < 6; k++)
			send_item(random_item());
		drain();

		write_reg(REG_BLEND, 32768);
		write_reg(REG_MIN_DIST, 256);
		write_reg(REG_MAX_DIST, 12800);
		write_reg(REG_UNUSED, 24'hFFFFFF);

		tab = '{
			row(mk(0, 0, 0, 0, 0, 0, 32767, 0, 0, 1), 1, 32768, 0),
			row(mk(20000, 5, -7, 0, 0, 0, 32767, 0, 0, 0), 1, 32768, 0),
			row(mk(20000, 0, 0, 0, 0, 0, 32767, 0, 0, 1), 1, 0, 32767),
			row(mk(-20000, 0, 0, 0, 0, 0, 32767, 0, 0, 1), 1, 0, -32767),
			row(mk(100, 0, 0, 0, 0, 0, -32768, 0, 0, 1), 1, 32768, -32768),
			row(mk(6528, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, 16384, 0),
			row(mk(1, 0, 0, 0, 0, 0, 32767, 0, 0, 1), 1, 32768, 32767),
			row(mk(100, 100, 100, 0, 0, 0, 32767, 32767, 32767, 1), 1, 32768, 32768),
			row(mk(0, 12800, 0, 0, 0, 0, 0, 16384, 0, 1), 1, 0, 16384),
			row(mk(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
				-32768, -32768, -32768, 1), 0, 0, 0),
			row(mk(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
				32767, 32767, 32767, 1), 0, 0, 0),
			row(mk(-8388608, 8388607, 0, 8388607, -8388608, 0, -32768, 32767, 0, 1), 0, 0, 0),
			row(mk(300, -400, 1200, -50, 60, 70, 1000, -20000, 9000, 1), 0, 0, 0),
			row(mk(5000, 5000, 0, 5100, 4900, 0, 23170, 23170, 0, 1), 0, 0, 0),
			row(mk(0, 0, -3000, 0, 0, 0, 0, 0, -32768, 1), 0, 0, 0)
		};
		foreach (tab[i]) begin
			send_item(tab[i].it);
			if (tab[i].typed)
				pending_results[pending_results.size() - 1] = tab[i].res;
			if (i % 4 == 3)
				gap($urandom_range(1, 5));
		end
		drain();

		random_phase(PHASE_ITEMS);

		// blend above unity, span not positive
		write_reg(REG_BLEND, 65535);
		write_reg(REG_MIN_DIST, 5000);
		write_reg(REG_MAX_DIST, 5000);
		random_phase(PHASE_ITEMS);

		// widest span, partial blend
		write_reg(REG_BLEND, $urandom_range(1, 32767));
		write_reg(REG_MIN_DIST, 0);
		write_reg(REG_MAX_DIST, 24'hFFFFFF);
		random_phase(PHASE_ITEMS);

		// inverted span
		write_reg(REG_MIN_DIST, 24'hFFFFFF);
		write_reg(REG_MAX_DIST, 0);
		random_phase(PHASE_ITEMS / 2);

		write_reg(REG_BLEND, 0);
		random_phase(PHASE_ITEMS / 4);

		for (int ph = 0; ph < 3; ph++) begin
			write_reg(REG_BLEND, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32768));
			write_reg(REG_MIN_DIST, $urandom_range(0, 1 << ($urandom_range(4, 23))));
			write_reg(REG_MAX_DIST, $urandom_range(0, 1 << ($urandom_range(8, 24))));
			random_phase(PHASE_ITEMS);
		end

		if (errors == 0)
			$display("[spatial_audio_attenuation_pan] OK");
		else
			$display("[spatial_audio_attenuation_pan] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/sap_pkg.sv
src/sap_isqrt.sv
src/sap_div.sv
src/spatial_audio_attenuation_pan.sv
test/tb_top.sv
